>>> design/nrtp_pkg.sv
// shared types and codes of the nested region tick profiler
`timescale 1ns / 1ps

package nrtp_pkg;

	localparam logic [1:0] KIND_ENTER = 2'd0;
	localparam logic [1:0] KIND_LEAVE = 2'd1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD_ID = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_RD_REC,
		S_LV_FRAME,
		S_LV_UPD,
		S_PA_FRAME,
		S_PA_UPD,
		S_EMIT
	} nrtp_state_t;

	typedef struct packed {
		logic [63:0] total;
		logic [63:0] root;
		logic [63:0] child;
		logic [31:0] calls;
		logic [63:0] bytes;
	} nrtp_rec_t;

	typedef struct packed {
		logic [7:0]  region;
		logic [63:0] start;
		logic [63:0] saved_root;
	} nrtp_frame_t;

	typedef struct packed {
		logic       clr_wr;
		logic       capture;
		logic       stk_rd;
		logic       tbl_rd;
		logic       tbl_rd_frame;
		logic       enter_wr;
		logic       leave_frame;
		logic       leave_wr;
		logic       parent_wr;
		logic       res_rec;
		logic       res_zero;
		logic [1:0] res_code;
		logic       emit;
	} nrtp_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       id_bad;
		logic       sp_empty;
		logic       sp_full;
		logic       clr_last;
		logic       out_free;
	} nrtp_sts_t;

endpackage

>>> design/nrtp_ctrl.sv
// controller state machine of the nested region tick profiler
`timescale 1ns / 1ps

module nrtp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  nrtp_pkg::nrtp_sts_t  sts,
	output nrtp_pkg::nrtp_cmd_t  cmd
);

	nrtp_pkg::nrtp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nrtp_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			nrtp_pkg::S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = nrtp_pkg::S_IDLE;
				end
			end
			nrtp_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = nrtp_pkg::S_DECODE;
				end
			end
			nrtp_pkg::S_DECODE: begin
				if (sts.kind == nrtp_pkg::KIND_LEAVE) begin
					if (sts.sp_empty) begin
						cmd.res_zero = 1'b1;
						cmd.res_code = nrtp_pkg::ST_EMPTY;
						state_d      = nrtp_pkg::S_EMIT;
					end else begin
						cmd.stk_rd = 1'b1;
						state_d    = nrtp_pkg::S_LV_FRAME;
					end
				end else if (sts.id_bad) begin
					cmd.res_zero = 1'b1;
					cmd.res_code = nrtp_pkg::ST_BAD_ID;
					state_d      = nrtp_pkg::S_EMIT;
				end else begin
					cmd.tbl_rd = 1'b1;
					state_d    = nrtp_pkg::S_RD_REC;
				end
			end
			nrtp_pkg::S_RD_REC: begin
				if (sts.kind == nrtp_pkg::KIND_ENTER && !sts.sp_full) begin
					cmd.enter_wr = 1'b1;
					cmd.res_code = nrtp_pkg::ST_OK;
				end else begin
					cmd.res_rec  = 1'b1;
					cmd.res_code = (sts.kind == nrtp_pkg::KIND_ENTER) ?
						nrtp_pkg::ST_FULL : nrtp_pkg::ST_OK;
				end
				state_d = nrtp_pkg::S_EMIT;
			end
			nrtp_pkg::S_LV_FRAME: begin
				cmd.leave_frame  = 1'b1;
				cmd.tbl_rd       = 1'b1;
				cmd.tbl_rd_frame = 1'b1;
				state_d          = nrtp_pkg::S_LV_UPD;
			end
			nrtp_pkg::S_LV_UPD: begin
				cmd.leave_wr = 1'b1;
				cmd.res_code = nrtp_pkg::ST_OK;
				if (sts.sp_empty) begin
					state_d = nrtp_pkg::S_EMIT;
				end else begin
					cmd.stk_rd = 1'b1;
					state_d    = nrtp_pkg::S_PA_FRAME;
				end
			end
			nrtp_pkg::S_PA_FRAME: begin
				cmd.tbl_rd       = 1'b1;
				cmd.tbl_rd_frame = 1'b1;
				state_d          = nrtp_pkg::S_PA_UPD;
			end
			nrtp_pkg::S_PA_UPD: begin
				cmd.parent_wr = 1'b1;
				state_d       = nrtp_pkg::S_EMIT;
			end
			nrtp_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = nrtp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = nrtp_pkg::S_CLEAR;
			end
		endcase
	end

endmodule

>>> design/nrtp_dp.sv
// datapath of the nested region tick profiler: region table, frame stack, result stage
`timescale 1ns / 1ps

module nrtp_dp #(
	parameter int REGION_COUNT = 256,
	parameter int STACK_DEPTH  = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nrtp_pkg::nrtp_cmd_t  cmd,
	output nrtp_pkg::nrtp_sts_t  sts,
	input  logic [1:0]           kind,
	input  logic [7:0]           region_id,
	input  logic [63:0]          byte_count,
	input  logic [63:0]          timestamp,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [7:0]           report_region,
	output logic [63:0]          total_ticks,
	output logic [63:0]          root_ticks,
	output logic [63:0]          child_ticks,
	output logic [31:0]          call_total,
	output logic [63:0]          bytes_last,
	output logic [6:0]           nesting_level,
	output logic [8:0]           region_span
);

	localparam int TBL_DEPTH = (REGION_COUNT < 256) ? REGION_COUNT : 256;
	localparam int TIW       = $clog2(TBL_DEPTH);
	localparam int SIW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SPW       = $clog2(STACK_DEPTH + 1);

	logic [1:0]  kind_q;
	logic [7:0]  id_q;
	logic [63:0] bytes_q;
	logic [63:0] ts_q;

	logic [SPW-1:0] sp_q;
	logic [8:0]     span_q;
	logic [TIW-1:0] clr_q;
	logic [63:0]    elapsed_q;

	nrtp_pkg::nrtp_rec_t   tbl_mem [TBL_DEPTH];
	nrtp_pkg::nrtp_rec_t   tbl_rd_q;
	nrtp_pkg::nrtp_frame_t stk_mem [STACK_DEPTH];
	nrtp_pkg::nrtp_frame_t stk_rd_q;

	logic [1:0]          res_status_q;
	logic [7:0]          res_region_q;
	nrtp_pkg::nrtp_rec_t res_rec_q;

	logic                out_valid_q;

	logic [TIW-1:0]      tbl_raddr;
	logic [TIW-1:0]      tbl_waddr;
	logic                tbl_we;
	nrtp_pkg::nrtp_rec_t tbl_wdata;
	nrtp_pkg::nrtp_rec_t enter_rec;
	nrtp_pkg::nrtp_rec_t leave_rec;
	nrtp_pkg::nrtp_rec_t parent_rec;
	nrtp_pkg::nrtp_frame_t push_frame;
	logic [SIW-1:0]      top_addr;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			id_q    <= region_id;
			bytes_q <= byte_count;
			ts_q    <= timestamp;
		end
	end

	// status toward the controller
	always_comb begin
		sts.kind     = kind_q;
		sts.id_bad   = (id_q == 8'd0) || (32'(id_q) >= REGION_COUNT);
		sts.sp_empty = (sp_q == '0);
		sts.sp_full  = (32'(sp_q) >= STACK_DEPTH);
		sts.clr_last = (clr_q == TIW'(TBL_DEPTH - 1));
		sts.out_free = !out_valid_q || !out_stall;
	end

	// record updates
	always_comb begin
		enter_rec       = tbl_rd_q;
		enter_rec.bytes = bytes_q;
		if (tbl_rd_q.calls != '1) begin
			enter_rec.calls = tbl_rd_q.calls + 32'd1;
		end

		leave_rec       = tbl_rd_q;
		leave_rec.total = tbl_rd_q.total + elapsed_q;
		leave_rec.root  = stk_rd_q.saved_root + elapsed_q;

		parent_rec       = tbl_rd_q;
		parent_rec.child = tbl_rd_q.child + elapsed_q;

		push_frame.region     = id_q;
		push_frame.start      = ts_q;
		push_frame.saved_root = tbl_rd_q.root;
	end

	assign top_addr  = SIW'(sp_q - SPW'(1));
	assign tbl_raddr = cmd.tbl_rd_frame ? stk_rd_q.region[TIW-1:0] : id_q[TIW-1:0];

	always_comb begin
		tbl_we    = 1'b1;
		tbl_waddr = clr_q;
		tbl_wdata = '0;
		if (cmd.enter_wr) begin
			tbl_waddr = id_q[TIW-1:0];
			tbl_wdata = enter_rec;
		end else if (cmd.leave_wr) begin
			tbl_waddr = stk_rd_q.region[TIW-1:0];
			tbl_wdata = leave_rec;
		end else if (cmd.parent_wr) begin
			tbl_waddr = stk_rd_q.region[TIW-1:0];
			tbl_wdata = parent_rec;
		end else if (!cmd.clr_wr) begin
			tbl_we = 1'b0;
		end
	end

	// region table
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (cmd.tbl_rd) begin
			tbl_rd_q <= tbl_mem[tbl_raddr];
		end
	end

	// frame stack
	always_ff @(posedge clk) begin
		if (cmd.enter_wr) begin
			stk_mem[SIW'(sp_q)] <= push_frame;
		end
		if (cmd.stk_rd) begin
			stk_rd_q <= stk_mem[top_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.leave_frame) begin
			elapsed_q <= ts_q - stk_rd_q.start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q   <= '0;
			span_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + TIW'(1);
			end
			if (cmd.enter_wr) begin
				sp_q <= sp_q + SPW'(1);
				if (span_q <= {1'b0, id_q}) begin
					span_q <= {1'b0, id_q} + 9'd1;
				end
			end else if (cmd.leave_frame) begin
				sp_q <= sp_q - SPW'(1);
			end
		end
	end

	// result assembly
	always_ff @(posedge clk) begin
		if (cmd.res_zero) begin
			res_status_q <= cmd.res_code;
			res_region_q <= (cmd.res_code == nrtp_pkg::ST_BAD_ID) ? id_q : 8'd0;
			res_rec_q    <= '0;
		end else if (cmd.res_rec) begin
			res_status_q <= cmd.res_code;
			res_region_q <= id_q;
			res_rec_q    <= tbl_rd_q;
		end else if (cmd.enter_wr) begin
			res_status_q <= cmd.res_code;
			res_region_q <= id_q;
			res_rec_q    <= enter_rec;
		end else if (cmd.leave_wr) begin
			res_status_q <= cmd.res_code;
			res_region_q <= stk_rd_q.region;
			res_rec_q    <= leave_rec;
		end else if (cmd.parent_wr && stk_rd_q.region == res_region_q) begin
			res_rec_q.child <= parent_rec.child;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status        <= res_status_q;
			report_region <= res_region_q;
			total_ticks   <= res_rec_q.total;
			root_ticks    <= res_rec_q.root;
			child_ticks   <= res_rec_q.child;
			call_total    <= res_rec_q.calls;
			bytes_last    <= res_rec_q.bytes;
			nesting_level <= 7'(sp_q);
			region_span   <= span_q;
		end
	end

	assign out_valid = out_valid_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= STACK_DEPTH)
		else $error("stack pointer beyond stack depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enter_wr |-> !sts.sp_full && !sts.id_bad)
		else $error("push on full stack or with invalid id");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.leave_frame |-> !sts.sp_empty)
		else $error("pop on empty stack");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result overwrites an item still waiting");

	a_span_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enter_wr |=> span_q > {1'b0, $past(id_q)})
		else $error("region span below entered id");

endmodule

>>> design/nested_region_tick_profiler.sv
// top level of the nested region tick profiler
// after reset all min(REGION_COUNT, 256) entries of the region table are cleared; no item is taken meanwhile
// an item is taken only in the idle state, so a new item waits until the result of the last one
// has been handed to the output register; a leave with a parent frame also updates the parent
// the result passes through the result stage and then the output register, which holds it while stalled
`timescale 1ns / 1ps

module nested_region_tick_profiler #(
	parameter int REGION_COUNT = 256,
	parameter int STACK_DEPTH  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  region_id,
	input  logic [63:0] byte_count,
	input  logic [63:0] timestamp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  report_region,
	output logic [63:0] total_ticks,
	output logic [63:0] root_ticks,
	output logic [63:0] child_ticks,
	output logic [31:0] call_total,
	output logic [63:0] bytes_last,
	output logic [6:0]  nesting_level,
	output logic [8:0]  region_span
);

	nrtp_pkg::nrtp_cmd_t cmd;
	nrtp_pkg::nrtp_sts_t sts;

	nrtp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	nrtp_dp #(
		.REGION_COUNT (REGION_COUNT),
		.STACK_DEPTH  (STACK_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (kind),
		.region_id     (region_id),
		.byte_count    (byte_count),
		.timestamp     (timestamp),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.report_region (report_region),
		.total_ticks   (total_ticks),
		.root_ticks    (root_ticks),
		.child_ticks   (child_ticks),
		.call_total    (call_total),
		.bytes_last    (bytes_last),
		.nesting_level (nesting_level),
		.region_span   (region_span)
	);

endmodule
